// ===== design/lz77td_pkg.sv =====
package lz77td_pkg;

  // history window and result packing
  localparam int unsigned HIST_DEPTH = 256;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned LANES      = 4;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned BYTE_W     = 8;

  // stream word layouts
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;

  // literal substitution
  localparam logic [BYTE_W-1:0] LIT_ZERO_CHAR = 8'h30;
  localparam logic [BYTE_W-1:0] LIT_SPACE     = 8'h20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_LIT
  } dec_state_t;

endpackage

// ===== design/lz77_triple_decoder.sv =====
// LZ77 triple decoder. Each input word carries one code (back offset, copy
// length, literal byte). With a nonzero offset the decoder copies copy_length
// bytes one at a time from offset bytes back in a 256-byte circular history,
// so overlapping copies repeat bytes written by the same copy; the literal
// (with '0' turned into a space) always follows. Decoded bytes leave packed
// four to an output word, with a byte count and tlast on the final word of
// the code. Unwritten history reads as zero. The history RAM has a
// registered read: each copied byte is read in ST_READ, then written and
// pushed in ST_COPY. A code with a zero offset or length goes straight
// to ST_LIT, which pushes the literal; both push states wait while the
// output word is stalled. in_tready is high only between codes;
// a finished output word can wait in the output register while the next
// code is accepted.
module lz77_triple_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // back_offset[7:0], copy_length[15:8], literal_byte[23:16]
  // output words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // byte_lane0..3[31:0], byte_count[34:32], zero pad[39:35]
  output logic        out_tlast   // last_of_code
);
  import lz77td_pkg::*;

  // sequencer and code registers
  dec_state_t          state_r, state_nxt;
  logic [HIST_AW-1:0]  off_r;
  logic [BYTE_W-1:0]   remain_r;
  logic [BYTE_W-1:0]   lit_r;
  logic [HIST_AW-1:0]  wp_r;

  // history memory, with valid bits standing for the all-zero reset
  logic [BYTE_W-1:0]   hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_vld_r;
  logic [BYTE_W-1:0]   rd_data_r;
  logic                rd_vld_r;
  logic [HIST_AW-1:0]  rd_addr;

  // packing buffer
  logic [BYTE_W-1:0]   pack_r [LANES];
  logic [CNT_W-1:0]    pack_cnt_r;

  // output register
  logic                out_vld_r;
  logic [BYTE_W-1:0]   out_lane_r [LANES];
  logic [CNT_W-1:0]    out_cnt_r;
  logic                out_last_r;

  // datapath control
  logic                in_acc;
  logic                out_free;
  logic                rd_en;
  logic                push;
  logic                push_final;
  logic [BYTE_W-1:0]   push_byte;
  logic [CNT_W-1:0]    cnt_new;
  logic                flush;
  logic [BYTE_W-1:0]   lit_in;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_vld_r || out_tready;
  assign rd_addr  = wp_r - off_r;
  assign lit_in   = (in_tdata[23:16] == LIT_ZERO_CHAR) ? LIT_SPACE : in_tdata[23:16];
  assign cnt_new  = pack_cnt_r + CNT_W'(1);
  assign flush    = push && ((cnt_new == CNT_W'(LANES)) || push_final);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if ((in_tdata[7:0] != 8'd0) && (in_tdata[15:8] != 8'd0)) state_nxt = ST_READ;
          else state_nxt = ST_LIT;
        end
      end
      ST_READ: state_nxt = ST_COPY;
      ST_COPY: begin
        if (out_free) begin
          if (remain_r == BYTE_W'(1)) state_nxt = ST_LIT;
          else state_nxt = ST_READ;
        end
      end
      ST_LIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready  = 1'b0;
    rd_en      = 1'b0;
    push       = 1'b0;
    push_final = 1'b0;
    push_byte  = lit_r;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_READ: rd_en = 1'b1;
      ST_COPY: begin
        push      = out_free;
        push_byte = rd_vld_r ? rd_data_r : '0;
      end
      ST_LIT: begin
        push       = out_free;
        push_final = 1'b1;
        push_byte  = lit_r;
      end
      default: in_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // code fields and copy counter
  always_ff @(posedge clk) begin
    if (in_acc) begin
      off_r    <= in_tdata[7:0];
      remain_r <= in_tdata[15:8];
      lit_r    <= lit_in;
    end else if (push && !push_final) begin
      remain_r <= remain_r - BYTE_W'(1);
    end
  end

  // write pointer and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      hist_vld_r <= '0;
    end else if (push) begin
      wp_r             <= wp_r + HIST_AW'(1);
      hist_vld_r[wp_r] <= 1'b1;
    end
  end

  // history ram: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (push) begin
      hist_mem[wp_r] <= push_byte;
    end
    if (rd_en) begin
      rd_data_r <= hist_mem[rd_addr];
      rd_vld_r  <= hist_vld_r[rd_addr];
    end
  end

  // packing buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_cnt_r <= '0;
    end else if (push) begin
      pack_cnt_r <= flush ? '0 : cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pack_r[pack_cnt_r[1:0]] <= push_byte;
    end
  end

  // output register, loaded when a word fills or the code ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (flush) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (flush) begin
      for (int i = 0; i < LANES; i++) begin
        if (CNT_W'(i) == pack_cnt_r) out_lane_r[i] <= push_byte;
        else if (CNT_W'(i) < pack_cnt_r) out_lane_r[i] <= pack_r[i];
        else out_lane_r[i] <= '0;
      end
      out_cnt_r  <= cnt_new;
      out_last_r <= push_final;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_cnt_r, out_lane_r[3], out_lane_r[2],
                       out_lane_r[1], out_lane_r[0]};

endmodule
